@@ hdl/ukcf_pkg.sv @@
// ----------------------------------------------------------------------------
// ukcf_pkg
// Shared types, constants and the frame byte table for the command framer.
// ----------------------------------------------------------------------------
`default_nettype none

package ukcf_pkg;

  localparam int MATCH_WIDTH_DEF = 6;
  localparam int QUEUE_DEPTH     = 4;
  localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);
  localparam int STEP_W          = 4;

  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] FRAME_FLAG = 8'h7E;

  localparam logic DEST_CONSOLE = 1'b0;
  localparam logic DEST_LINK    = 1'b1;

  // work queued by the front for the back to expand
  typedef enum logic [2:0] {
    OP_ECHO   = 3'd0,
    OP_CRLF   = 3'd1,
    OP_ON     = 3'd2,
    OP_OFF    = 3'd3,
    OP_TOGGLE = 3'd4
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;
  } cmd_t;

  typedef struct packed {
    logic       dest;
    logic [7:0] data;
    logic       last;
  } beat_t;

  // byte number 'step' of the burst that one queued request expands into
  function automatic beat_t frame_beat(cmd_t cmd, logic [STEP_W-1:0] step);
    beat_t b;
    b.dest = DEST_LINK;
    b.data = FRAME_FLAG;
    b.last = 1'b0;
    if (cmd.op == OP_ECHO) begin
      b.dest = DEST_CONSOLE;
      b.data = cmd.data;
      b.last = 1'b1;
    end else if (step == STEP_W'(0)) begin
      b.dest = DEST_CONSOLE;
      b.data = CHAR_CR;
    end else if (step == STEP_W'(1)) begin
      b.dest = DEST_CONSOLE;
      b.data = CHAR_LF;
      b.last = (cmd.op == OP_CRLF);
    end else begin
      case (cmd.op)
        OP_ON: begin
          case (step)
            STEP_W'(3): b.data = 8'h81;
            STEP_W'(4): b.data = 8'h02;
            STEP_W'(5): b.data = 8'h36;
            STEP_W'(6): b.data = 8'hF9;
            STEP_W'(7): b.data = 8'hF7;
            default:    b.data = FRAME_FLAG;
          endcase
          b.last = (step == STEP_W'(8));
        end
        OP_OFF: begin
          case (step)
            STEP_W'(3): b.data = 8'h81;
            STEP_W'(4): b.data = 8'h21;
            STEP_W'(5): b.data = 8'h45;
            default:    b.data = FRAME_FLAG;
          endcase
          b.last = (step == STEP_W'(6));
        end
        OP_TOGGLE: begin
          case (step)
            STEP_W'(3): b.data = 8'h82;
            STEP_W'(4): b.data = 8'h33;
            STEP_W'(5): b.data = 8'h24;
            STEP_W'(6): b.data = 8'h73;
            default:    b.data = FRAME_FLAG;
          endcase
          b.last = (step == STEP_W'(7));
        end
        default: begin
          b.last = 1'b1;
        end
      endcase
    end
    return b;
  endfunction

endpackage

`default_nettype wire

@@ hdl/uart_keyword_command_framer_top.sv @@
// ----------------------------------------------------------------------------
// uart_keyword_command_framer_top
// Console line framer: echoes bytes, and on carriage return sends CR LF and
// a flagged command frame when the line is "on", "off" or "toggle".
// ----------------------------------------------------------------------------
//  channel   ports                                   direction
//  input     in_valid in_ready in_rx_byte            in
//  result    out_valid out_ready out_dest            out
//            out_out_byte out_last
//
// A byte is accepted in any cycle the request queue has room; the queue
// holds four requests. The back end sends one byte per cycle unless
// stalled: an echo is one byte, a CR two to nine, set by the frame sequencer.
// Output goes through one register stage; stalls there back up the queue.
// Reset clears the line length, queue and output valid; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module uart_keyword_command_framer_top #(
  parameter int MATCH_WIDTH = ukcf_pkg::MATCH_WIDTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_rx_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            out_dest,
  output logic [7:0]      out_out_byte,
  output logic            out_last
);
  import ukcf_pkg::*;

  cmd_t push_cmd, head;
  logic push, full, pop, not_empty;

  ukcf_front #(.MATCH_WIDTH(MATCH_WIDTH)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .q_full     (full),
    .q_push     (push),
    .q_cmd      (push_cmd)
  );

  ukcf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (full),
    .pop       (pop),
    .not_empty (not_empty),
    .head      (head)
  );

  ukcf_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_not_empty  (not_empty),
    .q_head       (head),
    .q_pop        (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_dest     (out_dest),
    .out_out_byte (out_out_byte),
    .out_last     (out_last)
  );

endmodule

`default_nettype wire

@@ hdl/ukcf_front.sv @@
// ----------------------------------------------------------------------------
// ukcf_front
// Accepts console bytes, keeps the current line and classifies each byte
// into one request for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module ukcf_front #(
  parameter int MATCH_WIDTH = ukcf_pkg::MATCH_WIDTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [7:0]    in_rx_byte,
  input  wire logic          q_full,
  output logic               q_push,
  output ukcf_pkg::cmd_t     q_cmd
);
  import ukcf_pkg::*;

  localparam int LEN_W = $clog2(MATCH_WIDTH + 2);
  localparam int IDX_W = $clog2(MATCH_WIDTH);

  logic [7:0]       line_chars_r [MATCH_WIDTH];
  logic [LEN_W-1:0] line_len_r, line_len_nxt;
  logic             is_cr, hit_on, hit_off, hit_toggle;

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;
  assign is_cr    = (in_rx_byte == CHAR_CR);

  assign hit_on = (line_len_r == LEN_W'(2)) &&
                  (line_chars_r[0] == "o") && (line_chars_r[1] == "n");
  assign hit_off = (line_len_r == LEN_W'(3)) &&
                   (line_chars_r[0] == "o") && (line_chars_r[1] == "f") &&
                   (line_chars_r[2] == "f");
  assign hit_toggle = (line_len_r == LEN_W'(6)) &&
                      (line_chars_r[0] == "t") && (line_chars_r[1] == "o") &&
                      (line_chars_r[2] == "g") && (line_chars_r[3] == "g") &&
                      (line_chars_r[4] == "l") && (line_chars_r[5] == "e");

  always_comb begin
    q_cmd.data = in_rx_byte;
    if (!is_cr)          q_cmd.op = OP_ECHO;
    else if (hit_on)     q_cmd.op = OP_ON;
    else if (hit_off)    q_cmd.op = OP_OFF;
    else if (hit_toggle) q_cmd.op = OP_TOGGLE;
    else                 q_cmd.op = OP_CRLF;
  end

  // length saturates one past the stored width so long lines never match
  always_comb begin
    line_len_nxt = line_len_r;
    if (q_push) begin
      if (is_cr)
        line_len_nxt = '0;
      else if (line_len_r < LEN_W'(MATCH_WIDTH + 1))
        line_len_nxt = line_len_r + LEN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_len_r <= '0;
    end else begin
      line_len_r <= line_len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_push && !is_cr && (line_len_r < LEN_W'(MATCH_WIDTH))) begin
      line_chars_r[line_len_r[IDX_W-1:0]] <= in_rx_byte;
    end
  end

endmodule

`default_nettype wire

@@ hdl/ukcf_queue.sv @@
// ----------------------------------------------------------------------------
// ukcf_queue
// Short request queue between the front and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module ukcf_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire ukcf_pkg::cmd_t push_cmd,
  output logic                full,
  input  wire logic           pop,
  output logic                not_empty,
  output ukcf_pkg::cmd_t      head
);
  import ukcf_pkg::*;

  cmd_t              slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_pop;

  assign full      = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = slot_r[rd_ptr_r];
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !do_pop)      count_nxt = count_r + QCNT_W'(1);
    else if (!push && do_pop) count_nxt = count_r - QCNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

@@ hdl/ukcf_back.sv @@
// ----------------------------------------------------------------------------
// ukcf_back
// Expands each queued request into its output bytes, one per cycle when not
// stalled, into a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module ukcf_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           q_not_empty,
  input  wire ukcf_pkg::cmd_t q_head,
  output logic                q_pop,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic                out_dest,
  output logic [7:0]          out_out_byte,
  output logic                out_last
);
  import ukcf_pkg::*;

  logic [STEP_W-1:0] step_r, step_nxt;
  logic              out_valid_r, out_valid_nxt;
  beat_t             beat_r, beat;
  logic              load;

  assign beat  = frame_beat(q_head, step_r);
  // output stage takes a new byte when empty or drained this cycle
  assign load  = q_not_empty && (!out_valid_r || out_ready);
  assign q_pop = load && beat.last;

  always_comb begin
    step_nxt = step_r;
    if (load) step_nxt = beat.last ? '0 : step_r + STEP_W'(1);
    out_valid_nxt = out_valid_r;
    if (load)           out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      beat_r <= beat;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_dest     = beat_r.dest;
  assign out_out_byte = beat_r.data;
  assign out_last     = beat_r.last;

endmodule

`default_nettype wire

@@ sim/tb_uart_keyword_command_framer_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_uart_keyword_command_framer_top
// Feeds console lines (keywords, near misses, long lines, empty lines, noise)
// through valid/ready, predicts the echo and command frame bytes per request
// and checks each output beat in order, under four idle/stall mixes.
// ----------------------------------------------------------------------------
module tb_uart_keyword_command_framer_top;
  import ukcf_pkg::*;

  localparam int LINE_KEEP        = MATCH_WIDTH_DEF;
  localparam int STALL_LIMIT      = 2000;
  localparam int RANDOM_PER_PHASE = 36;

  // frame bodies, right-aligned, first byte in the highest used byte
  localparam logic [39:0] BODY_ON     = 40'h81_02_36_F9_F7;
  localparam logic [39:0] BODY_OFF    = 40'h00_00_81_21_45;
  localparam logic [39:0] BODY_TOGGLE = 40'h00_82_33_24_73;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_rx_byte;
  logic       out_valid;
  logic       out_ready;
  logic       out_dest;
  logic [7:0] out_out_byte;
  logic       out_last;

  logic [7:0] console_q[$];   // bytes still to send
  beat_t      pending_tx[$];  // predicted output beats, oldest first

  logic [7:0] line_buf [LINE_KEEP];
  logic [$clog2(LINE_KEEP + 2)-1:0] line_len;

  int gap_pct;
  int stall_pct;
  int errors;
  int quiet_cycles;

  uart_keyword_command_framer_top dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_rx_byte   (in_rx_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_dest     (out_dest),
    .out_out_byte (out_out_byte),
    .out_last     (out_last)
  );

  always #5 clk = ~clk;

  function automatic bit roll(int pct);
    return $urandom_range(99) < pct;
  endfunction

  function automatic void queue_tx(logic dest, logic [7:0] data, logic is_last);
    beat_t b;
    b.dest = dest;
    b.data = data;
    b.last = is_last;
    pending_tx.push_back(b);
  endfunction

  function automatic bit line_matches(string kw);
    if (int'(line_len) != kw.len()) return 1'b0;
    for (int i = 0; i < kw.len(); i++) begin
      if (line_buf[i] != kw[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // line state update and expected beats for one accepted request
  function automatic void track_console_byte(logic [7:0] rx);
    op_t         kind;
    logic [39:0] body;
    int          body_n;
    if (rx != CHAR_CR) begin
      if (line_len < LINE_KEEP) line_buf[line_len] = rx;
      if (line_len < LINE_KEEP + 1) line_len = line_len + 1'b1;
      queue_tx(DEST_CONSOLE, rx, 1'b1);
      return;
    end
    kind   = OP_CRLF;
    body   = '0;
    body_n = 0;
    if (line_matches("on")) begin
      kind = OP_ON;
      body = BODY_ON;
      body_n = 5;
    end else if (line_matches("off")) begin
      kind = OP_OFF;
      body = BODY_OFF;
      body_n = 3;
    end else if (line_matches("toggle")) begin
      kind = OP_TOGGLE;
      body = BODY_TOGGLE;
      body_n = 4;
    end
    queue_tx(DEST_CONSOLE, CHAR_CR, 1'b0);
    queue_tx(DEST_CONSOLE, CHAR_LF, kind == OP_CRLF);
    if (kind != OP_CRLF) begin
      queue_tx(DEST_LINK, FRAME_FLAG, 1'b0);
      for (int i = 0; i < body_n; i++) begin
        queue_tx(DEST_LINK, body[8*(body_n-1-i) +: 8], 1'b0);
      end
      queue_tx(DEST_LINK, FRAME_FLAG, 1'b1);
    end
    line_len = '0;
  endfunction

  function automatic logic [7:0] random_text_byte();
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(255));
    end while (b == CHAR_CR);
    return b;
  endfunction

  task automatic queue_chars(string s);
    for (int i = 0; i < s.len(); i++) begin
      console_q.push_back(s[i]);
    end
  endtask

  task automatic queue_random_lines(int budget);
    logic [7:0] chars[$];
    string      kw;
    int         added;
    int         kind;
    int         n;
    added = 0;
    while (added < budget) begin
      chars.delete();
      case ($urandom_range(2))
        0:       kw = "on";
        1:       kw = "off";
        default: kw = "toggle";
      endcase
      kind = $urandom_range(99);
      if (kind < 55) begin
        for (int i = 0; i < kw.len(); i++) chars.push_back(kw[i]);
        // near miss: one bit off, one char too many or one too few
        if (kind >= 40) begin
          case ($urandom_range(2))
            0: begin
              n = $urandom_range(chars.size() - 1);
              chars[n] = chars[n] ^ (8'h01 << $urandom_range(7));
            end
            1:       chars.push_back(random_text_byte());
            default: void'(chars.pop_back());
          endcase
        end
      end else if (kind < 68) begin
        n = $urandom_range(5, 1);
        repeat (n) chars.push_back(8'($urandom_range(25) + 8'h61));
      end else if (kind < 76) begin
        // empty line
      end else if (kind < 88) begin
        n = $urandom_range(12, 7);
        repeat (n) chars.push_back(random_text_byte());
      end else begin
        // noise, CR allowed anywhere
        n = $urandom_range(4, 1);
        repeat (n) chars.push_back(8'($urandom_range(255)));
      end
      if (kind < 88) chars.push_back(CHAR_CR);
      foreach (chars[i]) console_q.push_back(chars[i]);
      added += chars.size();
    end
  endtask

  // request driver
  always @(posedge clk) begin : drive_requests
    logic busy;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      busy = in_valid;
      if (in_valid && in_ready) begin
        track_console_byte(in_rx_byte);
        busy = 1'b0;
      end
      if (!busy) begin
        if (console_q.size() != 0 && !roll(gap_pct)) begin
          in_rx_byte <= console_q.pop_front();
          in_valid   <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output monitor and receiver stalls
  always @(posedge clk) begin : check_beats
    beat_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= !roll(stall_pct);
      if (out_valid && out_ready) begin
        if (pending_tx.size() == 0) begin
          $display("%0t: unexpected beat dest %0d byte %02h last %0d", $time,
                   out_dest, out_out_byte, out_last);
          errors++;
        end else begin
          want = pending_tx.pop_front();
          if (out_dest !== want.dest) begin
            $display("%0t: dest mismatch expected %0d actual %0d", $time,
                     want.dest, out_dest);
            errors++;
          end
          if (out_out_byte !== want.data) begin
            $display("%0t: byte mismatch expected %02h actual %02h", $time,
                     want.data, out_out_byte);
            errors++;
          end
          if (out_last !== want.last) begin
            $display("%0t: last mismatch expected %0d actual %0d", $time,
                     want.last, out_last);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_rx_byte   = 8'h00;
    out_ready    = 1'b0;
    gap_pct      = 0;
    stall_pct    = 0;
    errors       = 0;
    quiet_cycles = 0;
    line_len     = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 77; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 77; end
        default: begin gap_pct = 31; stall_pct = 31; end
      endcase
      if (ph == 0) begin
        // overlong line starting with a keyword, then a match to show the clear
        queue_chars("toggle");
        console_q.push_back(8'h00);
        console_q.push_back(8'hFF);
        console_q.push_back(CHAR_CR);
        queue_chars("on");
        console_q.push_back(CHAR_CR);
        queue_chars("off");
        console_q.push_back(CHAR_CR);
        console_q.push_back(CHAR_CR);
        queue_chars("toggle");
        console_q.push_back(CHAR_CR);
      end
      queue_random_lines(RANDOM_PER_PHASE);
      // hold off until every predicted beat is out
      while (console_q.size() != 0 || in_valid || pending_tx.size() != 0) begin
        @(posedge clk);
      end
    end

    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
